[hw/rtl/lru_block_buffer_cache_defines.svh]
// ----------------------------------------------------------------------------
// lru_block_buffer_cache_defines
// Assertion macros for the LRU block buffer cache, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef LRU_BLOCK_BUFFER_CACHE_DEFINES_SVH
`define LRU_BLOCK_BUFFER_CACHE_DEFINES_SVH
`ifndef SYNTHESIS
`define LBC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LBC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LBC_ASSERT(label, clk, rstn, prop, msg)
`define LBC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[hw/rtl/lbc_pkg.sv]
// ----------------------------------------------------------------------------
// lbc_pkg
// Types, constants and command structs for the LRU block buffer cache.
// ----------------------------------------------------------------------------
`default_nettype none
package lbc_pkg;
    localparam int ENTRIES  = 32;
    localparam int REF_MAX  = 63;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int RANK_W   = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(REF_MAX + 1);
    localparam int SLOT_W   = 5;

    typedef enum logic [1:0] {
        MODE_GET     = 2'd0,
        MODE_WRITE   = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_DONE    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_BUF  = 2'd1,
        ST_NOT_HELD = 2'd2,
        ST_CNT_FULL = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  device;
        logic [31:0] block_number;
        logic [4:0]  slot;
    } in_item_t;

    typedef struct packed {
        logic [4:0] entry;
        logic       hit;
        logic       need_read;
        logic       need_write;
        logic [1:0] status;
    } out_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input item
        logic exec;     // decide and update state
    } lbc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic dummy_ok;
    } lbc_sts_t;
endpackage
`default_nettype wire

[hw/rtl/lbc_datapath.sv]
// ----------------------------------------------------------------------------
// lbc_datapath
// Entry arrays, parallel tag match, victim choice and recency update.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lru_block_buffer_cache_defines.svh"
module lbc_datapath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire lbc_pkg::lbc_cmd_t cmd,
    output lbc_pkg::lbc_sts_t      sts,
    input  wire lbc_pkg::in_item_t in_item,
    output lbc_pkg::out_item_t     out_item
);
    import lbc_pkg::*;

    logic [7:0]        tdev_reg  [ENTRIES];
    logic [31:0]       tblk_reg  [ENTRIES];
    logic [CNT_W-1:0]  cnt_reg   [ENTRIES];
    logic [RANK_W-1:0] rank_reg  [ENTRIES];
    logic [ENTRIES-1:0] valid_reg, dirty_reg;
    in_item_t  req_reg;
    out_item_t res_reg, res_next;

    // tag match vector, registered so the priority pick stays short
    logic [ENTRIES-1:0] match;
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = (tdev_reg[i] == in_item.device) && (tblk_reg[i] == in_item.block_number);
        end
    end
    logic [ENTRIES-1:0] match_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg   <= in_item;
            match_reg <= match;
        end
    end

    // pick most recent match and least recent free entry by rank decode
    logic [ENTRIES-1:0] free;
    logic               found, vfound;
    logic [IDX_W-1:0]   fidx, vidx;
    logic [ENTRIES-1:0] m_by_rank, f_by_rank;
    logic [IDX_W-1:0]   idx_of_rank [ENTRIES];
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            free[i] = (cnt_reg[i] == '0) && !dirty_reg[i];
        end
        for (int r = 0; r < ENTRIES; r++) begin
            idx_of_rank[r] = '0;
            m_by_rank[r]   = 1'b0;
            f_by_rank[r]   = 1'b0;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            idx_of_rank[rank_reg[i]] = IDX_W'(i);
            m_by_rank[rank_reg[i]]   = match_reg[i];
            f_by_rank[rank_reg[i]]   = free[i];
        end
        found = |m_by_rank;
        vfound = |f_by_rank;
        fidx = '0;
        vidx = '0;
        for (int r = 0; r < ENTRIES; r++) begin
            if (m_by_rank[r]) fidx = idx_of_rank[r];
        end
        for (int r = ENTRIES - 1; r >= 0; r--) begin
            if (f_by_rank[r]) vidx = idx_of_rank[r];
        end
    end

    logic [IDX_W-1:0] sidx;
    logic             slot_ok;
    assign sidx    = req_reg.slot[IDX_W-1:0];
    assign slot_ok = ({27'd0, req_reg.slot} < 32'(ENTRIES));

    // result decision
    always_comb begin
        res_next = '0;
        res_next.entry = req_reg.slot;
        case (mode_t'(req_reg.mode))
            MODE_GET: begin
                res_next.entry = '0;
                if (found) begin
                    res_next.entry = 5'(fidx);
                    res_next.hit   = 1'b1;
                    if ({2'b0, cnt_reg[fidx]} >= 8'(REF_MAX)) begin
                        res_next.status = ST_CNT_FULL;
                    end else begin
                        res_next.need_read = !valid_reg[fidx];
                    end
                end else if (vfound) begin
                    res_next.entry     = 5'(vidx);
                    res_next.need_read = 1'b1;
                end else begin
                    res_next.status = ST_NO_BUF;
                end
            end
            MODE_DONE: begin
                if (!slot_ok) res_next.status = ST_NOT_HELD;
            end
            default: begin
                if (!slot_ok || cnt_reg[sidx] == '0) begin
                    res_next.status = ST_NOT_HELD;
                end else if (req_reg.mode == MODE_WRITE) begin
                    res_next.need_write = 1'b1;
                end
            end
        endcase
    end

    // state update
    logic [RANK_W-1:0] rel_rank;
    assign rel_rank = rank_reg[sidx];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                tdev_reg[i] <= '0;
                tblk_reg[i] <= '0;
                cnt_reg[i]  <= '0;
                rank_reg[i] <= RANK_W'(i);
            end
            valid_reg <= '0;
            dirty_reg <= '0;
        end else if (cmd.exec) begin
            res_reg <= res_next;
            case (mode_t'(req_reg.mode))
                MODE_GET: begin
                    if (found) begin
                        if (res_next.status == ST_OK) cnt_reg[fidx] <= cnt_reg[fidx] + 1'b1;
                    end else if (vfound) begin
                        tdev_reg[vidx]  <= req_reg.device;
                        tblk_reg[vidx]  <= req_reg.block_number;
                        valid_reg[vidx] <= 1'b0;
                        dirty_reg[vidx] <= 1'b0;
                        cnt_reg[vidx]   <= CNT_W'(1);
                    end
                end
                MODE_DONE: begin
                    if (slot_ok) begin
                        valid_reg[sidx] <= 1'b1;
                        dirty_reg[sidx] <= 1'b0;
                    end
                end
                MODE_WRITE: begin
                    if (res_next.status == ST_OK) dirty_reg[sidx] <= 1'b1;
                end
                default: begin
                    if (res_next.status == ST_OK) begin
                        cnt_reg[sidx] <= cnt_reg[sidx] - 1'b1;
                        if (cnt_reg[sidx] == CNT_W'(1)) begin
                            for (int i = 0; i < ENTRIES; i++) begin
                                if (rank_reg[i] > rel_rank) rank_reg[i] <= rank_reg[i] - 1'b1;
                            end
                            rank_reg[sidx] <= RANK_W'(ENTRIES - 1);
                        end
                    end
                end
            endcase
        end
    end

    assign out_item = res_reg;
    assign sts.dummy_ok = vfound | found;

    `LBC_ASSERT(a_cnt_bound, aclk, aresetn, cmd.exec |=> ({2'b0, cnt_reg[0]} <= 8'(REF_MAX)), "count above maximum")
    `LBC_ASSERT(a_no_both, aclk, aresetn, !(cmd.load && cmd.exec), "load and exec together")
    `LBC_ASSERT(a_get_hit, aclk, aresetn, (cmd.exec && req_reg.mode == MODE_GET && found) |=> res_reg.hit, "hit lost")
endmodule
`default_nettype wire

[hw/rtl/lbc_ctrl.sv]
// ----------------------------------------------------------------------------
// lbc_ctrl
// Handshake sequencer: accept, execute, present result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lru_block_buffer_cache_defines.svh"
module lbc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire lbc_pkg::lbc_sts_t sts,
    output lbc_pkg::lbc_cmd_t      cmd
);
    import lbc_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        unused_sts;
    assign unused_sts = sts.dummy_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    // next state: the next item may load in the same cycle the waiting result is taken
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                m_valid = 1'b1;
                s_ready = m_ready;
                if (m_ready) begin
                    if (s_valid) begin
                        cmd.load   = 1'b1;
                        state_next = S_EXEC;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    `LBC_ASSERT(a_exec_after_load, aclk, aresetn, cmd.load |=> cmd.exec, "exec missing")
    `LBC_ASSERT(a_out_after_exec, aclk, aresetn, cmd.exec |=> m_valid, "result missing")
    `LBC_ASSERT(a_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid, "result dropped")
endmodule
`default_nettype wire

[hw/rtl/lru_block_buffer_cache.sv]
// ----------------------------------------------------------------------------
// lru_block_buffer_cache
// LRU disk block buffer cache, tag and policy side.
// ----------------------------------------------------------------------------
// Usage: one item on s_ (valid/ready) carries mode, device, block number and
// slot; one result item leaves on m_ for each. Get searches the tags from
// most to least recent, on a miss recycles the least recent clean idle
// entry. Write, release and transfer done act on an entry by slot.
// Sequence: the accept registers the item and its tag match, the execute
// state decides and updates the arrays, and the result is shown from then on.
// The next item is taken in the same cycle the waiting result is taken, and
// no new item is accepted while the last one is still executing.
// Reset (aresetn low, synchronous) clears tags, counts and marks and sets
// recency by index, highest index most recent. No clearing pass.
// When the receiver stalls the result holds on m_ and no item is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module lru_block_buffer_cache (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire lbc_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output lbc_pkg::out_item_t      m_data
);
    import lbc_pkg::*;

    lbc_cmd_t cmd;
    lbc_sts_t sts;

    lbc_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .sts, .cmd
    );

    lbc_datapath u_dp (
        .aclk, .aresetn, .cmd, .sts, .in_item(s_data), .out_item(m_data)
    );
endmodule
`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU block buffer cache: random get, write,
// release and transfer-done items against a behavioural model of the tags,
// counts, marks and recency order, with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
    import lbc_pkg::*;

    // Behavioural model of the cache plus the queue of expected result items
    class cache_scoreboard;
        logic [7:0]  dev_tag [ENTRIES];
        logic [31:0] blk_tag [ENTRIES];
        int          refs    [ENTRIES];
        bit          valid_b [ENTRIES];
        bit          dirty_b [ENTRIES];
        int          rank    [ENTRIES];
        out_item_t   pending_results [$];
        int          errors;
        int          checked;

        function void clear();
            for (int i = 0; i < ENTRIES; i++) begin
                dev_tag[i] = '0; blk_tag[i] = '0; refs[i] = 0;
                valid_b[i] = 0; dirty_b[i] = 0; rank[i] = i;
            end
            pending_results.delete();
            errors = 0;
            checked = 0;
        endfunction

        function void note_request(in_item_t it);
            out_item_t r;
            int found, victim, s, rk;
            r = '0;
            s = int'(it.slot);
            found = -1;
            victim = -1;
            if (mode_t'(it.mode) == MODE_GET) begin
                for (int i = 0; i < ENTRIES; i++)
                    if (dev_tag[i] == it.device && blk_tag[i] == it.block_number)
                        if (found < 0 || rank[i] > rank[found]) found = i;
                if (found >= 0) begin
                    r.entry = 5'(found);
                    r.hit = 1;
                    if (refs[found] >= REF_MAX) begin
                        r.status = ST_CNT_FULL;
                    end else begin
                        refs[found]++;
                        r.need_read = !valid_b[found];
                        r.status = ST_OK;
                    end
                end else begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (refs[i] == 0 && !dirty_b[i])
                            if (victim < 0 || rank[i] < rank[victim]) victim = i;
                    if (victim < 0) begin
                        r.status = ST_NO_BUF;
                    end else begin
                        dev_tag[victim] = it.device;
                        blk_tag[victim] = it.block_number;
                        valid_b[victim] = 0;
                        dirty_b[victim] = 0;
                        refs[victim] = 1;
                        r.entry = 5'(victim);
                        r.need_read = 1;
                        r.status = ST_OK;
                    end
                end
            end else begin
                r.entry = it.slot;
                if (s >= ENTRIES) begin
                    r.status = ST_NOT_HELD;
                end else if (mode_t'(it.mode) == MODE_DONE) begin
                    valid_b[s] = 1;
                    dirty_b[s] = 0;
                end else if (refs[s] == 0) begin
                    r.status = ST_NOT_HELD;
                end else if (mode_t'(it.mode) == MODE_WRITE) begin
                    dirty_b[s] = 1;
                    r.need_write = 1;
                end else begin
                    refs[s]--;
                    if (refs[s] == 0) begin
                        rk = rank[s];
                        for (int i = 0; i < ENTRIES; i++)
                            if (rank[i] > rk) rank[i]--;
                        rank[s] = ENTRIES - 1;
                    end
                end
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result item %h", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.entry !== want.entry) begin
                $display("%0t: entry exp %0d got %0d", $time, want.entry, got.entry);
                errors++;
            end
            if (got.hit !== want.hit) begin
                $display("%0t: hit exp %0d got %0d", $time, want.hit, got.hit);
                errors++;
            end
            if (got.need_read !== want.need_read) begin
                $display("%0t: need_read exp %0d got %0d", $time, want.need_read,
                         got.need_read);
                errors++;
            end
            if (got.need_write !== want.need_write) begin
                $display("%0t: need_write exp %0d got %0d", $time, want.need_write,
                         got.need_write);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    cache_scoreboard sb;
    bit        stim_done;
    bit        quiet_rx;
    int        sent;
    int        hits_seen;
    int        full_seen;
    int        nobuf_seen;

    lru_block_buffer_cache u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock
    always begin
        aclk = 1'b0; #6;
        aclk = 1'b1; #6;
    end

    // Offer one item, hold it until accepted, then note it in the model;
    // valid drops only when a gap follows, so back-to-back items never
    // see two updates of valid in one step
    task automatic send_item(input mode_t md, input logic [7:0] dv,
                             input logic [31:0] bn, input logic [4:0] sl,
                             input bit nogap);
        in_item_t it;
        int gap;
        it.mode = md;
        it.device = dv;
        it.block_number = bn;
        it.slot = sl;
        gap = nogap ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(it);
        sent++;
    endtask

    // Small pools of devices and blocks so hits and recycles are frequent
    function automatic logic [31:0] pick_block();
        case ($urandom_range(0, 4))
            0: pick_block = $urandom;
            1: pick_block = 32'hFFFF_FFFF;
            default: pick_block = $urandom_range(0, 40);
        endcase
    endfunction

    function automatic logic [7:0] pick_device();
        case ($urandom_range(0, 4))
            0: pick_device = 8'($urandom);
            1: pick_device = 8'hFF;
            default: pick_device = 8'($urandom_range(0, 2));
        endcase
    endfunction

    // Result side: random stalls, stretches of no stall, checks each item
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = quiet_rx ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (m_data.hit) hits_seen++;
            if (m_data.status == ST_CNT_FULL) full_seen++;
            if (m_data.status == ST_NO_BUF) nobuf_seen++;
            sb.check_result(m_data);
        end
    end

    // Stimulus
    initial begin
        int m;
        bit burst;
        sb = new();
        sb.clear();
        s_valid = 1'b0;
        s_data = '0;
        aresetn = 1'b0;
        stim_done = 0;
        quiet_rx = 0;
        sent = 0;
        hits_seen = 0;
        full_seen = 0;
        nobuf_seen = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: duplicate reset tags, not-held errors, transfer done
        send_item(MODE_GET, 8'd0, 32'd0, 5'd0, 0);
        send_item(MODE_RELEASE, 8'd0, 32'd0, 5'd0, 0);
        send_item(MODE_WRITE, 8'd0, 32'd0, 5'd3, 0);
        send_item(MODE_DONE, 8'd0, 32'd0, 5'd31, 0);
        send_item(MODE_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31, 0);
        send_item(MODE_WRITE, 8'd0, 32'd0, 5'd0, 1);
        send_item(MODE_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0, 1);
        send_item(MODE_DONE, 8'd0, 32'd0, 5'd0, 1);
        send_item(MODE_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0, 1);
        send_item(MODE_RELEASE, 8'd0, 32'd0, 5'd0, 0);
        // Count full: hold one block up to the limit and beyond
        for (int i = 0; i < REF_MAX + 1; i++)
            send_item(MODE_GET, 8'h5A, 32'h1234_5678, 5'd0, 1);
        for (int i = 0; i < REF_MAX; i++)
            send_item(MODE_RELEASE, 8'd0, 32'd0, 5'd0, 1);
        // No free buffer: hold every entry, then one more miss
        for (int i = 0; i < ENTRIES + 1; i++)
            send_item(MODE_GET, 8'd7, 32'd1000 + i, 5'd0, 1);
        for (int i = 0; i < ENTRIES; i++)
            send_item(MODE_RELEASE, 8'd0, 32'd0, i[4:0], 1);

        // Random part: mostly well-formed traffic on a small tag pool
        for (int n = 0; n < 600; n++) begin
            if (n % 100 == 50) quiet_rx = !quiet_rx;
            burst = (n % 200) >= 150;
            m = $urandom_range(0, 9);
            if (m < 4)
                send_item(MODE_GET, pick_device(), pick_block(), 5'($urandom), burst);
            else if (m < 5)
                send_item(MODE_WRITE, 8'($urandom), $urandom, 5'($urandom), burst);
            else if (m < 8)
                send_item(MODE_RELEASE, 8'($urandom), $urandom, 5'($urandom), burst);
            else
                send_item(MODE_DONE, 8'($urandom), $urandom, 5'($urandom), burst);
        end
        s_valid <= 1'b0;
        stim_done = 1;
    end

    // End of run once all expected results have arrived
    initial begin
        @(posedge aclk iff stim_done);
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Sent %0d items, checked %0d results", sent, sb.checked);
        $display("Hits %0d, count-full %0d, no-buffer %0d", hits_seen, full_seen,
                 nobuf_seen);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
